// File: hdl/mph_pkg.sv
// Package for the migration pattern histogrammer: operation codes, store
// state codes, request structure and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mph_pkg;

	localparam int DEF_CPU_COUNT    = 8;
	localparam int DEF_HANDOFF_BINS = 5;

	// widest addresses over the parameter ranges (64 cpus, 64 bins)
	localparam int CELL_AW_MAX = 12;
	localparam int BIN_AW_MAX  = 6;

	localparam int LEN_W = 32;
	localparam int CNT_W = 64;

	typedef enum logic [1:0] {
		FN_EVENT   = 2'd0,
		FN_RD_CELL = 2'd1,
		FN_RD_BIN  = 2'd2,
		FN_FLUSH   = 2'd3
	} mph_func_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} mph_state_t;

	// work handed from the run tracker to the counter store
	typedef struct packed {
		logic                   mx_wr;
		logic                   hs_wr;
		logic                   mx_rd_ok;
		logic                   hs_rd_ok;
		logic                   idx_err;
		logic [CELL_AW_MAX-1:0] mx_addr;
		logic [BIN_AW_MAX-1:0]  hs_addr;
		logic [LEN_W-1:0]       mx_add;
		logic [CNT_W-1:0]       total;
	} mph_req_t;

endpackage

`default_nettype wire

// File: hdl/mph_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mph_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/mph_tracker.sv
// Run tracker: last-event and open-run registers, decides commits and reads
// for each accepted beat. Depends on mph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mph_tracker #(
	parameter int CPU_COUNT    = mph_pkg::DEF_CPU_COUNT,
	parameter int HANDOFF_BINS = mph_pkg::DEF_HANDOFF_BINS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             acc,
	input  wire logic [1:0]       func,
	input  wire logic [21:0]      task_id,
	input  wire logic [2:0]       from_cpu,
	input  wire logic [2:0]       to_cpu,
	input  wire logic [5:0]       read_index,
	output mph_pkg::mph_req_t     req
);

	localparam int CELL_COUNT = CPU_COUNT * CPU_COUNT;

	mph_pkg::mph_func_t fn;

	logic                      have_q;
	logic [21:0]               prev_task_q;
	logic [2:0]                prev_from_q, prev_to_q;
	logic [mph_pkg::LEN_W-1:0] pp_len_q, ho_len_q;
	logic [2:0]                pp_from_q, pp_to_q;
	logic [mph_pkg::CNT_W-1:0] total_q;

	logic                      same, rev, commit, pp_in_range;
	logic [mph_pkg::LEN_W-1:0] bin_full;

	assign fn = mph_pkg::mph_func_t'(func);

	assign same   = have_q && (task_id == prev_task_q);
	assign rev    = (prev_from_q == to_cpu) && (prev_to_q == from_cpu);
	assign commit = (fn == mph_pkg::FN_FLUSH) || ((fn == mph_pkg::FN_EVENT) && have_q && !same);

	assign pp_in_range = ({4'b0, pp_from_q} < 7'(CPU_COUNT)) && ({4'b0, pp_to_q} < 7'(CPU_COUNT));

	// long hand-offs land in the last bin
	assign bin_full = (ho_len_q > mph_pkg::LEN_W'(HANDOFF_BINS)) ?
		mph_pkg::LEN_W'(HANDOFF_BINS - 1) : (ho_len_q - mph_pkg::LEN_W'(1));

	always_comb begin
		req          = '0;
		req.mx_addr  = mph_pkg::CELL_AW_MAX'(pp_from_q) * mph_pkg::CELL_AW_MAX'(CPU_COUNT)
			+ mph_pkg::CELL_AW_MAX'(pp_to_q);
		req.hs_addr  = bin_full[mph_pkg::BIN_AW_MAX-1:0];
		req.mx_add   = pp_len_q;
		req.mx_wr    = commit && (pp_len_q != '0) && pp_in_range;
		req.hs_wr    = commit && (ho_len_q != '0);
		case (fn)
			mph_pkg::FN_EVENT: begin
				req.total = total_q + mph_pkg::CNT_W'(1);
			end
			mph_pkg::FN_FLUSH: begin
				req.total = total_q;
			end
			mph_pkg::FN_RD_CELL: begin
				req.mx_addr  = mph_pkg::CELL_AW_MAX'(read_index);
				req.mx_rd_ok = {7'b0, read_index} < 13'(CELL_COUNT);
			end
			mph_pkg::FN_RD_BIN: begin
				req.hs_addr  = mph_pkg::BIN_AW_MAX'(read_index);
				req.hs_rd_ok = {1'b0, read_index} < 7'(HANDOFF_BINS);
				req.idx_err  = !req.hs_rd_ok;
			end
			default: begin
				req.total = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			prev_task_q <= '0;
			prev_from_q <= '0;
			prev_to_q   <= '0;
			pp_len_q    <= '0;
			pp_from_q   <= '0;
			pp_to_q     <= '0;
			ho_len_q    <= '0;
			total_q     <= '0;
		end else if (acc) begin
			if (commit) begin
				pp_len_q <= '0;
				ho_len_q <= '0;
			end
			if (fn == mph_pkg::FN_EVENT) begin
				if (same && rev) begin
					if (pp_len_q == '0) begin
						pp_from_q <= prev_from_q;
						pp_to_q   <= prev_to_q;
					end
					if (pp_len_q != '1) begin
						pp_len_q <= pp_len_q + mph_pkg::LEN_W'(1);
					end
				end else if (same) begin
					if (ho_len_q != '1) begin
						ho_len_q <= ho_len_q + mph_pkg::LEN_W'(1);
					end
				end
				have_q      <= 1'b1;
				prev_task_q <= task_id;
				prev_from_q <= from_cpu;
				prev_to_q   <= to_cpu;
				total_q     <= total_q + mph_pkg::CNT_W'(1);
			end else if (fn == mph_pkg::FN_FLUSH) begin
				have_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/mph_store.sv
// Counter store: matrix and histogram RAMs, clear pass after reset,
// read-modify-write with forwarding of the last write. Depends on mph_pkg, mph_ram.
`timescale 1ns / 1ps
`default_nettype none

module mph_store #(
	parameter int CPU_COUNT    = mph_pkg::DEF_CPU_COUNT,
	parameter int HANDOFF_BINS = mph_pkg::DEF_HANDOFF_BINS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      acc,
	input  wire logic                      adv,
	input  wire mph_pkg::mph_req_t         req,
	output logic                           busy,
	output logic                           res_valid,
	output logic [mph_pkg::CNT_W-1:0]      res_value,
	output logic                           res_err
);

	localparam int CELL_COUNT = CPU_COUNT * CPU_COUNT;
	localparam int CW         = $clog2(CELL_COUNT);
	localparam int BW         = (HANDOFF_BINS > 1) ? $clog2(HANDOFF_BINS) : 1;
	localparam int CLR_N      = (CELL_COUNT > HANDOFF_BINS) ? CELL_COUNT : HANDOFF_BINS;
	localparam int CLR_W      = $clog2(CLR_N);

	mph_pkg::mph_state_t state_q, state_d;
	logic [CLR_W-1:0]    clr_cnt_q;
	logic                clr_last;

	logic              valid_s1;
	mph_pkg::mph_req_t req_s1;

	logic                      mx_we, hs_we;
	logic [CW-1:0]             mx_waddr;
	logic [BW-1:0]             hs_waddr;
	logic [mph_pkg::CNT_W-1:0] mx_wdata, hs_wdata, mx_rdata, hs_rdata;
	logic [mph_pkg::CNT_W-1:0] mx_fwd, hs_fwd;
	logic [mph_pkg::CNT_W:0]   mx_sum, hs_sum;
	logic                      mx_commit, hs_commit;

	// last write to each RAM, for a read issued on the same edge
	logic                      mx_lw_valid_q, hs_lw_valid_q;
	logic [CW-1:0]             mx_lw_addr_q;
	logic [BW-1:0]             hs_lw_addr_q;
	logic [mph_pkg::CNT_W-1:0] mx_lw_data_q, hs_lw_data_q;

	assign busy     = (state_q == mph_pkg::ST_CLEAR);
	assign clr_last = (clr_cnt_q == CLR_W'(CLR_N - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			mph_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = mph_pkg::ST_RUN;
				end
			end
			mph_pkg::ST_RUN: begin
				state_d = mph_pkg::ST_RUN;
			end
			default: begin
				state_d = mph_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mph_pkg::ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (busy) begin
				clr_cnt_q <= clr_cnt_q + CLR_W'(1);
			end
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_s1 <= req;
		end
	end

	assign mx_fwd = (mx_lw_valid_q && (mx_lw_addr_q == req_s1.mx_addr[CW-1:0])) ?
		mx_lw_data_q : mx_rdata;
	assign hs_fwd = (hs_lw_valid_q && (hs_lw_addr_q == req_s1.hs_addr[BW-1:0])) ?
		hs_lw_data_q : hs_rdata;

	assign mx_sum = {1'b0, mx_fwd} + {33'b0, req_s1.mx_add};
	assign hs_sum = {1'b0, hs_fwd} + (mph_pkg::CNT_W + 1)'(1);

	assign mx_commit = valid_s1 && adv && req_s1.mx_wr;
	assign hs_commit = valid_s1 && adv && req_s1.hs_wr;

	always_comb begin
		if (busy) begin
			mx_we    = {1'b0, clr_cnt_q} < (CLR_W + 1)'(CELL_COUNT);
			hs_we    = {1'b0, clr_cnt_q} < (CLR_W + 1)'(HANDOFF_BINS);
			mx_waddr = clr_cnt_q[CW-1:0];
			hs_waddr = clr_cnt_q[BW-1:0];
			mx_wdata = '0;
			hs_wdata = '0;
		end else begin
			mx_we    = mx_commit;
			hs_we    = hs_commit;
			mx_waddr = req_s1.mx_addr[CW-1:0];
			hs_waddr = req_s1.hs_addr[BW-1:0];
			mx_wdata = mx_sum[mph_pkg::CNT_W] ? '1 : mx_sum[mph_pkg::CNT_W-1:0];
			hs_wdata = hs_sum[mph_pkg::CNT_W] ? '1 : hs_sum[mph_pkg::CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mx_lw_valid_q <= 1'b0;
			hs_lw_valid_q <= 1'b0;
		end else begin
			mx_lw_valid_q <= !busy && (mx_lw_valid_q || mx_commit);
			hs_lw_valid_q <= !busy && (hs_lw_valid_q || hs_commit);
		end
	end

	always_ff @(posedge clk) begin
		if (mx_commit) begin
			mx_lw_addr_q <= mx_waddr;
			mx_lw_data_q <= mx_wdata;
		end
		if (hs_commit) begin
			hs_lw_addr_q <= hs_waddr;
			hs_lw_data_q <= hs_wdata;
		end
	end

	mph_ram #(
		.WIDTH(mph_pkg::CNT_W),
		.DEPTH(CELL_COUNT)
	) u_matrix (
		.clk  (clk),
		.we   (mx_we),
		.waddr(mx_waddr),
		.wdata(mx_wdata),
		.re   (acc),
		.raddr(req.mx_addr[CW-1:0]),
		.rdata(mx_rdata)
	);

	mph_ram #(
		.WIDTH(mph_pkg::CNT_W),
		.DEPTH(HANDOFF_BINS)
	) u_hist (
		.clk  (clk),
		.we   (hs_we),
		.waddr(hs_waddr),
		.wdata(hs_wdata),
		.re   (acc),
		.raddr(req.hs_addr[BW-1:0]),
		.rdata(hs_rdata)
	);

	assign res_valid = valid_s1;
	assign res_err   = req_s1.idx_err;
	assign res_value = req_s1.mx_rd_ok ? mx_fwd :
		(req_s1.hs_rd_ok ? hs_fwd : req_s1.total);

endmodule

`default_nettype wire

// File: hdl/migration_pattern_histogrammer_top.sv
// Top level of the migration pattern histogrammer: handshakes and result
// register. Depends on mph_pkg, mph_tracker, mph_store.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  Input channel (in_valid / in_stall) carries one beat per operation:
//  a migration event, a matrix cell read, a histogram bin read or a flush.
//  Output channel (out_valid / out_stall) returns exactly one beat per input
//  beat, in order: the counter read, or the event total for events and
//  flushes; index_error flags a histogram read past the last bin.
//  Throughput: one beat per cycle while the receiver does not stall and no
//  clear sweep runs. An accepted beat passes the tracker registers and RAM
//  read, then write-back and the result register. Each memory does one
//  read and one write per cycle; a read that hits the entry written on the
//  same edge is forwarded.
//  Reset: run state and counters clear; the RAMs are then swept to zero,
//  one entry per cycle, max(CPU_COUNT*CPU_COUNT, HANDOFF_BINS) entries in all,
//  with in_stall held high.
//  Receiver stall: the result register holds, the pipeline freezes behind it
//  and in_stall rises in the same cycle; no beat is lost or repeated.

module migration_pattern_histogrammer_top #(
	parameter int CPU_COUNT    = mph_pkg::DEF_CPU_COUNT,
	parameter int HANDOFF_BINS = mph_pkg::DEF_HANDOFF_BINS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [1:0]   func,
	input  wire logic [21:0]  task_id,
	input  wire logic [2:0]   from_cpu,
	input  wire logic [2:0]   to_cpu,
	input  wire logic [5:0]   read_index,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [63:0]       value,
	output logic              index_error
);

	logic                      adv;   // pipeline moves this cycle
	logic                      acc;   // input beat taken
	logic                      busy;  // clear sweep running
	mph_pkg::mph_req_t         req;
	logic                      res_valid, res_err;
	logic [mph_pkg::CNT_W-1:0] res_value;

	logic                      out_valid_q;
	logic [mph_pkg::CNT_W-1:0] value_q;
	logic                      index_error_q;

	// the result register frees itself when its beat leaves
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv || busy;
	assign acc      = in_valid && !in_stall;

	mph_tracker #(
		.CPU_COUNT   (CPU_COUNT),
		.HANDOFF_BINS(HANDOFF_BINS)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.func      (func),
		.task_id   (task_id),
		.from_cpu  (from_cpu),
		.to_cpu    (to_cpu),
		.read_index(read_index),
		.req       (req)
	);

	mph_store #(
		.CPU_COUNT   (CPU_COUNT),
		.HANDOFF_BINS(HANDOFF_BINS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.adv      (adv),
		.req      (req),
		.busy     (busy),
		.res_valid(res_valid),
		.res_value(res_value),
		.res_err  (res_err)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			value_q       <= res_value;
			index_error_q <= res_err;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign index_error = index_error_q;

	// a bin read past the end returns zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_error |-> value == '0)
		else $error("index_error with nonzero value");

	// nothing enters during the clear sweep
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("input accepted during clear sweep");

	// the clear sweep runs once after reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("clear sweep restarted");

	// a held result stays put while the receiver stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(value_q))
		else $error("result register changed under stall");

endmodule

`default_nettype wire
